[src/pau_pkg.sv]
// Shared constants, types and helpers for the polynomial arithmetic unit.
package pau_pkg;

  localparam int MaxDegree = 15;
  localparam int FracBits  = 16;
  localparam int NStore    = MaxDegree + 1;
  localparam int NWork     = 2 * MaxDegree + 1;
  localparam int SlotW     = 4;
  localparam int PowW      = 5;
  localparam int WorkW     = 56;

  localparam logic [1:0] KindLoadA = 2'd0;
  localparam logic [1:0] KindLoadB = 2'd1;
  localparam logic [1:0] KindStart = 2'd2;

  localparam logic [1:0] OpAdd = 2'd0;
  localparam logic [1:0] OpSub = 2'd1;
  localparam logic [1:0] OpMul = 2'd2;
  localparam logic [1:0] OpDiv = 2'd3;

  localparam logic [1:0] PartMain = 2'd0;
  localparam logic [1:0] PartQuot = 2'd1;
  localparam logic [1:0] PartRem  = 2'd2;

  // Request to the shared signed divider.
  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [63:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [55:0] sat56(input logic signed [63:0] v);
    logic signed [63:0] mx;
    logic signed [63:0] mn;
    mx = (64'sd1 <<< 55) - 64'sd1;
    mn = -(64'sd1 <<< 55);
    if (v > mx) return mx[55:0];
    if (v < mn) return mn[55:0];
    return v[55:0];
  endfunction

endpackage

[src/pau_divider.sv]
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module pau_divider
  import pau_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [63:0] rem;
  logic [63:0] quo;
  logic [31:0] dmag;
  logic        neg;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [64:0] trial;
  logic [63:0] num_mag;

  assign num_mag = req.num[63] ? 64'(-req.num) : req.num;
  assign trial   = {rem, quo[63]} - {33'd0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        rem  <= '0;
        quo  <= num_mag;
        dmag <= req.den[31] ? 32'(-req.den) : req.den;
        neg  <= req.num[63] ^ req.den[31];
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = neg ? 64'(-quo) : quo;

endmodule

[src/polynomial_arithmetic_unit.sv]
// Top level: operand stores, sequencer with shared multiplier and divider.
// Loads write one store entry. Add or subtract works term by term; multiply passes each
// coefficient pair through the single shared multiplier. Each result is registered.
// Divide starts the divider for each quotient term (64 divider steps, then done) and
// updates each lower term. A new request is accepted once the last result has been taken.
// Synchronous active-high reset clears the sequencer and output valid; stores hold.
module polynomial_arithmetic_unit
  import pau_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: opcode[1:0], coef_slot[5:2], coef_in[37:6], degree_a[41:38], degree_b[45:42]
  input  logic [47:0] s_tdata,
  // tuser: item_kind
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: power[4:0], coef_out[36:5], status[37]
  output logic [39:0] m_tdata,
  // tuser: part
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  typedef enum logic [9:0] {
    StIdle  = 10'b0000000001,
    StAdd   = 10'b0000000010,
    StMul   = 10'b0000000100,
    StMulAc = 10'b0000001000,
    StEmit  = 10'b0000010000,
    StDivQ  = 10'b0000100000,
    StDivW  = 10'b0001000000,
    StDivS  = 10'b0010000000,
    StOut   = 10'b0100000000,
    StDivU  = 10'b1000000000
  } state_t;

  state_t state;
  logic signed [31:0] a_mem [NStore];
  logic signed [31:0] b_mem [NStore];
  logic signed [55:0] work  [NWork];
  logic signed [31:0] quot  [NStore];

  logic [1:0]  op;
  logic [3:0]  da, db;
  logic [4:0]  i, j, top, rtop;
  logic [4:0]  qi;
  logic        lead_zero_done;
  logic signed [63:0] prod;
  logic signed [31:0] qval;
  div_req_t dreq;
  div_rsp_t drsp;

  // Output staging: emit phase sequence.
  logic [1:0] ph; // 0 main, 1 quotient, 2 remainder
  logic [4:0] ei;

  logic [1:0]  s_kind;
  logic [1:0]  s_op;
  logic [3:0]  s_slot;
  logic signed [31:0] s_coef;
  logic [3:0]  s_da, s_db;
  assign s_kind = s_tuser;
  assign s_op   = s_tdata[1:0];
  assign s_slot = s_tdata[5:2];
  assign s_coef = s_tdata[37:6];
  assign s_da   = s_tdata[41:38];
  assign s_db   = s_tdata[45:42];

  assign s_tready = (state == StIdle) && !m_tvalid;

  pau_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic signed [31:0] am, bm, mul_x;
  logic signed [63:0] add_a, add_b;
  assign am = a_mem[i[3:0]];
  assign bm = b_mem[j[3:0]];
  // The divide update multiplies the current quotient term by B[j].
  assign mul_x = (state == StEmit) ? qval : am;
  assign add_a = (i <= 5'(da)) ? 64'(am) : 64'sd0;
  assign add_b = (i <= 5'(db)) ? 64'(b_mem[i[3:0]]) : 64'sd0;

  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = 64'(work[qi + 5'(db)]) <<< FracBits;
    dreq.den   = b_mem[db];
    if (state == StDivQ) dreq.start = 1'b1;
  end

  // Finds the highest nonzero remainder term at or below rtop.
  logic [5:0] trimmed;
  always_comb begin
    trimmed = 6'h3f;
    for (int k = 0; k < NStore; k++)
      if (5'(k) <= rtop && work[k] != 0) trimmed = 6'(k);
  end

  logic signed [31:0] out_coef;
  logic               out_status;
  logic               out_last;
  always_comb begin
    out_status = lead_zero_done;
    out_coef   = '0;
    out_last   = 1'b0;
    if (lead_zero_done) out_last = 1'b1;
    else begin
      case (ph)
        PartMain: begin
          out_coef = sat32(64'(work[ei]));
          out_last = (ei == top);
        end
        PartQuot: begin
          out_coef = quot[ei[3:0]];
          out_last = (ei == top) && (trimmed == 6'h3f);
        end
        PartRem: begin
          out_coef = work[ei][31:0];
          out_last = (ei == rtop);
        end
        default: out_last = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= StIdle;
      m_tvalid <= 1'b0;
    end else begin
      if (state == StOut && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        StIdle: begin
          if (s_tvalid && s_tready) begin
            if (s_kind == KindLoadA) a_mem[s_slot] <= s_coef;
            else if (s_kind == KindLoadB) b_mem[s_slot] <= s_coef;
            else if (s_kind == KindStart) begin
              op <= s_op;
              da <= s_da;
              db <= s_db;
              i  <= '0;
              j  <= '0;
              // A divide starts from operand A; every other term starts cleared.
              for (int k = 0; k < NWork; k++)
                work[k] <= (s_op == OpDiv && k <= int'(s_da)) ? 56'(a_mem[4'(k)]) : '0;
              for (int k = 0; k < NStore; k++) quot[k] <= '0;
              lead_zero_done <= (s_op == OpDiv) && (b_mem[s_db] == 0);
              if (s_op == OpMul) state <= StMul;
              else if (s_op == OpDiv) begin
                if (b_mem[s_db] == 0) begin
                  ph <= PartQuot; ei <= '0; top <= '0; rtop <= '0;
                  state <= StOut;
                end else if (s_db > s_da) begin
                  ph <= PartQuot; ei <= '0; top <= '0;
                  rtop <= 5'(s_da);
                  state <= StDivS;
                end else begin
                  qi <= 5'(s_da - s_db);
                  top <= 5'(s_da - s_db);
                  rtop <= 5'(s_db) - 5'd1;
                  state <= StDivQ;
                end
              end else state <= StAdd;
            end
          end
        end
        StAdd: begin
          // One term per cycle; results stored then emitted.
          work[i] <= 56'(sat32((op == OpAdd) ? add_a + add_b : add_a - add_b));
          if (i == 5'((da > db) ? da : db)) begin
            top <= i; ph <= PartMain; ei <= '0; state <= StOut;
          end
          i <= i + 5'd1;
        end
        StMul: begin
          prod  <= 64'(mul_x) * 64'(bm);
          state <= StMulAc;
        end
        StMulAc: begin
          work[i + j] <= sat56(64'(work[i + j]) + (prod >>> FracBits));
          if (j == 5'(db)) begin
            j <= '0;
            i <= i + 5'd1;
            if (i == 5'(da)) begin
              top <= 5'(da) + 5'(db); ph <= PartMain; ei <= '0; state <= StOut;
            end else state <= StMul;
          end else begin
            j <= j + 5'd1;
            state <= StMul;
          end
        end
        StDivQ: begin
          state <= StDivW;
        end
        StDivW: begin
          if (drsp.done) begin
            qval <= sat32(drsp.quo);
            quot[qi[3:0]] <= sat32(drsp.quo);
            j <= '0;
            state <= StEmit;
          end
        end
        StEmit: begin
          // Divide update: j-th lower term loses the product of q and B[j].
          if (j < 5'(db)) begin
            prod  <= 64'(mul_x) * 64'(bm);
            state <= StDivU;
          end else begin
            work[qi + 5'(db)] <= '0;
            if (qi == 5'd0) begin
              ph <= PartQuot; ei <= '0; state <= StDivS;
            end else begin
              qi <= qi - 5'd1; state <= StDivQ;
            end
          end
        end
        StDivU: begin
          work[qi + j] <= 56'(sat32(64'(work[qi + j]) - (prod >>> FracBits)));
          j <= j + 5'd1;
          state <= StEmit;
        end
        StDivS: begin
          state <= StOut;
        end
        StOut: begin
          if (!m_tvalid || m_tready) begin
            m_tuser <= ph;
            m_tdata <= {2'b00, out_status, out_coef, ei};
            m_tlast <= out_last;
            if (out_last) state <= StIdle;
            if (ph == PartQuot && ei == top) begin
              ei <= '0; ph <= PartRem; rtop <= trimmed[4:0];
            end else ei <= ei + 5'd1;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state != StIdle) |-> !s_tready)
    else $error("accepted item while busy");
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> (state == StDivW))
    else $error("divider finished outside wait");
  assert property (@(posedge clk) disable iff (rst)
    (state == StDivQ) |-> !drsp.busy)
    else $error("divider started while busy");

endmodule

[tb/tb_polynomial_arithmetic_unit.sv]
// Self-checking testbench for the polynomial arithmetic unit, with driver, monitor and predictor.
`timescale 1ns / 1ps

module tb_polynomial_arithmetic_unit
  import pau_pkg::*;
();

  typedef struct {
    logic        hold;
    logic [1:0]  kind;
    logic [1:0]  op;
    logic [3:0]  slot;
    logic [31:0] coef;
    logic [3:0]  deg_a;
    logic [3:0]  deg_b;
  } request_t;

  typedef struct {
    logic [1:0]  part;
    logic [4:0]  power;
    logic [31:0] coef;
    logic        status;
    logic        last;
  } term_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  request_t pending_q[$];
  term_t    term_q[$];
  longint   a_coefs[NStore];
  longint   b_coefs[NStore];
  int       sent_count;
  int       error_count;
  int       idle_cycles;
  int       stall_left;
  bit       stall_done;
  bit       waiting_drain;

  polynomial_arithmetic_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clip56(longint v);
    longint mx;
    longint mn;
    mx = (64'sd1 <<< 55) - 1;
    mn = -(64'sd1 <<< 55);
    if (v > mx) return mx;
    if (v < mn) return mn;
    return v;
  endfunction

  function automatic void push_term(logic [1:0] part, int power, longint coef, logic status);
    term_t t;
    t.part = part;
    t.power = power[4:0];
    t.coef = coef[31:0];
    t.status = status;
    t.last = 1'b0;
    term_q.push_back(t);
  endfunction

  // Computes the coefficient stream that one accepted request produces.
  function automatic void predict_poly(logic [1:0] kind, logic [1:0] op, logic [3:0] slot,
                                       logic [31:0] coef, logic [3:0] dga, logic [3:0] dgb);
    longint wrk[NWork];
    longint quo[NStore];
    longint lead;
    longint q;
    int     da;
    int     db;
    int     top;
    int     first;
    int     i;
    int     j;
    da = int'(dga);
    db = int'(dgb);
    if (kind == KindLoadA) begin
      a_coefs[slot] = longint'($signed(coef));
      return;
    end
    if (kind == KindLoadB) begin
      b_coefs[slot] = longint'($signed(coef));
      return;
    end
    if (kind != KindStart) return;
    first = term_q.size();
    for (i = 0; i < NWork; i++) wrk[i] = 0;
    for (i = 0; i < NStore; i++) quo[i] = 0;
    if (op == OpAdd || op == OpSub) begin
      top = da > db ? da : db;
      for (i = 0; i <= top; i++) begin
        longint x;
        longint y;
        x = i <= da ? a_coefs[i] : 0;
        y = i <= db ? b_coefs[i] : 0;
        push_term(PartMain, i, clip32(op == OpAdd ? x + y : x - y), 1'b0);
      end
    end else if (op == OpMul) begin
      for (i = 0; i <= da; i++)
        for (j = 0; j <= db; j++)
          wrk[i + j] = clip56(wrk[i + j] + ((a_coefs[i] * b_coefs[j]) >>> FracBits));
      for (i = 0; i <= da + db; i++) push_term(PartMain, i, clip32(wrk[i]), 1'b0);
    end else begin
      lead = b_coefs[db];
      if (lead == 0) begin
        push_term(PartQuot, 0, 0, 1'b1);
      end else begin
        for (i = 0; i <= da; i++) wrk[i] = a_coefs[i];
        if (db > da) begin
          push_term(PartQuot, 0, 0, 1'b0);
          top = da;
        end else begin
          for (i = da - db; i >= 0; i--) begin
            q = clip32((wrk[i + db] <<< FracBits) / lead);
            quo[i] = q;
            for (j = 0; j < db; j++)
              wrk[i + j] = clip32(wrk[i + j] - ((q * b_coefs[j]) >>> FracBits));
            wrk[i + db] = 0;
          end
          for (i = 0; i <= da - db; i++) push_term(PartQuot, i, quo[i], 1'b0);
          top = db - 1;
        end
        while (top >= 0 && wrk[top] == 0) top--;
        for (i = 0; i <= top; i++) push_term(PartRem, i, wrk[i], 1'b0);
      end
    end
    if (term_q.size() > first) term_q[term_q.size() - 1].last = 1'b1;
  endfunction

  function automatic int idle_pct(bit sender);
    if (sent_count < 70) return 0;
    if (sent_count < 140) return sender ? 46 : 0;
    if (sent_count < 210) return sender ? 0 : 46;
    return 32;
  endfunction

  // Driver: records predictions on acceptance, then offers the next request.
  always @(posedge clk) begin
    request_t r;
    bit       hold_now;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
      waiting_drain <= 1'b0;
      sent_count <= 0;
    end else begin
      hold_now = waiting_drain;
      if (s_tvalid && s_tready) begin
        predict_poly(s_tuser, s_tdata[1:0], s_tdata[5:2], s_tdata[37:6], s_tdata[41:38],
                     s_tdata[45:42]);
        sent_count <= sent_count + 1;
      end
      if (hold_now && term_q.size() == 0) hold_now = 1'b0;
      if (!s_tvalid || s_tready) begin
        if (!hold_now && pending_q.size() > 0 && pending_q[0].hold) begin
          void'(pending_q.pop_front());
          hold_now = 1'b1;
        end
        if (hold_now || pending_q.size() == 0 || $urandom_range(99) < idle_pct(1)) begin
          s_tvalid <= 1'b0;
        end else begin
          r = pending_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= r.kind;
          s_tdata <= {2'b00, r.deg_b, r.deg_a, r.coef, r.slot, r.op};
        end
      end
      waiting_drain <= hold_now;
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    term_t t;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
      stall_done <= 1'b0;
      error_count <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (term_q.size() == 0) begin
          $error("unexpected result: power %0d coef %h", m_tdata[4:0], m_tdata[36:5]);
          error_count <= error_count + 1;
        end else begin
          t = term_q.pop_front();
          if (m_tuser !== t.part || m_tdata[4:0] !== t.power || m_tdata[36:5] !== t.coef ||
              m_tdata[37] !== t.status || m_tlast !== t.last) begin
            if (m_tuser !== t.part) $error("part: expected %0d, got %0d", t.part, m_tuser);
            if (m_tdata[4:0] !== t.power)
              $error("power: expected %0d, got %0d", t.power, m_tdata[4:0]);
            if (m_tdata[36:5] !== t.coef)
              $error("coef_out: expected %h, got %h", t.coef, m_tdata[36:5]);
            if (m_tdata[37] !== t.status)
              $error("status: expected %0d, got %0d", t.status, m_tdata[37]);
            if (m_tlast !== t.last) $error("last: expected %0d, got %0d", t.last, m_tlast);
            error_count <= error_count + 1;
          end
        end
      end
      // One long hold-off lets the unit back up into its input side.
      if (!stall_done && sent_count >= 180) begin
        stall_done <= 1'b1;
        stall_left <= 400;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= idle_pct(0));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 20000) begin
      $display("tb_polynomial_arithmetic_unit: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void add_request(logic [1:0] kind, logic [1:0] op, logic [3:0] slot,
                                      logic [31:0] coef, logic [3:0] da, logic [3:0] db);
    request_t r;
    r.hold = 1'b0;
    r.kind = kind;
    r.op = op;
    r.slot = slot;
    r.coef = coef;
    r.deg_a = da;
    r.deg_b = db;
    pending_q.push_back(r);
  endfunction

  function automatic void add_hold();
    request_t r;
    r = '{default: '0};
    r.hold = 1'b1;
    pending_q.push_back(r);
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return $urandom_range(1, 4) << FracBits;
      2: return -($urandom_range(1, 4) << FracBits);
      3: return $urandom_range(0, 3) ? $urandom() : 32'h7fff_ffff;
      4: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int i;
    int n;
    logic [3:0] da;
    logic [3:0] db;
    rst = 1'b1;
    // Every store entry is written before any operation reads it.
    for (i = 0; i < NStore; i++) begin
      add_request(KindLoadA, OpAdd, 4'(i), 32'h7fff_ffff, 4'd0, 4'd0);
      add_request(KindLoadB, OpAdd, 4'(i), 32'h7fff_ffff, 4'd0, 4'd0);
    end
    add_request(KindStart, OpAdd, 4'd0, 32'd0, 4'd15, 4'd15);
    add_request(KindStart, OpMul, 4'd0, 32'd0, 4'd15, 4'd15);
    add_request(KindLoadB, OpAdd, 4'd3, 32'h8000_0000, 4'd0, 4'd0);
    add_request(KindStart, OpSub, 4'd0, 32'd0, 4'd15, 4'd3);
    add_request(2'd3, OpDiv, 4'd5, 32'hffff_ffff, 4'd2, 4'd1);
    add_request(KindLoadB, OpAdd, 4'd1, 32'h0000_0000, 4'd0, 4'd0);
    add_request(KindStart, OpDiv, 4'd0, 32'd0, 4'd4, 4'd1);
    add_request(KindStart, OpDiv, 4'd0, 32'd0, 4'd2, 4'd5);
    add_request(KindStart, OpDiv, 4'd0, 32'd0, 4'd15, 4'd0);
    add_request(KindLoadA, OpAdd, 4'd0, 32'h0001_0000, 4'd0, 4'd0);
    add_request(KindLoadA, OpAdd, 4'd1, 32'h0002_0000, 4'd0, 4'd0);
    add_request(KindLoadB, OpAdd, 4'd0, 32'h0001_0000, 4'd0, 4'd0);
    add_request(KindLoadB, OpAdd, 4'd1, 32'h0001_0000, 4'd0, 4'd0);
    // This division is not exact: it leaves a nonzero remainder.
    add_request(KindStart, OpDiv, 4'd0, 32'd0, 4'd1, 4'd1);
    add_request(KindStart, OpMul, 4'd0, 32'd0, 4'd0, 4'd0);
    add_hold();
    n = 0;
    while (n < 230) begin
      da = 4'($urandom_range(0, 3) ? $urandom_range(0, 4) : $urandom_range(0, 15));
      db = 4'($urandom_range(0, 3) ? $urandom_range(0, 4) : $urandom_range(0, 15));
      repeat ($urandom_range(0, 5)) begin
        add_request(2'($urandom_range(0, 1)), 2'($urandom()), 4'($urandom()), rand_coef(),
                    4'($urandom()), 4'($urandom()));
        n++;
      end
      if ($urandom_range(0, 9) == 0) begin
        add_request(2'd3, 2'($urandom()), 4'($urandom()), $urandom(), 4'($urandom()),
                    4'($urandom()));
        n++;
      end
      add_request(KindStart, 2'($urandom()), 4'($urandom()), $urandom(), da, db);
      n++;
      if (n > 100 && n < 108) add_hold();
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (pending_q.size() > 0 || s_tvalid || waiting_drain || term_q.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
    if (error_count == 0 && term_q.size() == 0) begin
      $display("tb_polynomial_arithmetic_unit: done, clean");
    end else begin
      $display("tb_polynomial_arithmetic_unit: done, errors");
    end
    $finish;
  end

endmodule
